[rtl/core/mmpid_pkg.sv]
// Shared types and constants for the multi-motor PID position loop.
// Used by the channel interfaces and by the top level; depends on nothing.

package mmpid_pkg;

    localparam int MOTORS      = 2;
    localparam int TICK_PERIOD = 10;

    localparam int MIDX_W     = 1;
    localparam int POS_W      = 16;
    localparam int ERR_W      = POS_W + 1;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 40;
    localparam int MAG_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SPEED_LIMIT = 126;
    localparam int MILLI       = 1000;

    // Gain products: unsigned gain widened by one sign bit, times a signed operand
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KD_W   = GAIN_W + 1 + DELTA_W;

    localparam int PER_W   = $clog2(TICK_PERIOD + 1) + 1;
    localparam int MILLI_W = $clog2(MILLI + 1) + 1;
    localparam int NUM_W   = INTEG_W + PER_W + 8;

    // Speed = num / DIVISOR; any magnitude at or above SAT_NUM clamps to the limit
    localparam int DIVISOR = MILLI * TICK_PERIOD;
    localparam int SAT_NUM = SPEED_LIMIT * DIVISOR;
    localparam int LO_W    = $clog2(SAT_NUM);

    // Reciprocal multiply, exact for every magnitude below 2**LO_W
    localparam int RECIP_SHIFT = LO_W + $clog2(DIVISOR) + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int QPROD_W = LO_W + RECIP_W;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_STOP = 2'd2
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_MIN_POS = 3'd3,
        CFG_MAX_POS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [MIDX_W-1:0]       motor_index;
        logic signed [POS_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [MIDX_W-1:0] motor_id;
        logic [MAG_W-1:0]  speed_magnitude;
        logic              forward;
    } cmd_t;

endpackage

[rtl/core/mmpid_if.sv]
// Valid/ready channel interfaces for the PID position loop: requests in, drive commands out.
// Depends on mmpid_pkg for the payload structs.

interface mmpid_req_if;
    import mmpid_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mmpid_cmd_if;
    import mmpid_pkg::*;

    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/multi_motor_pid_position_loop.sv]
// Per-motor PID position loop: set-target, tick and stop requests in, drive commands out.
// Depends on mmpid_pkg and the channel interfaces in mmpid_if.sv.
//
//  channel | dir | carries                                    | request taken when
//  --------+-----+--------------------------------------------+--------------------
//  req     | in  | req_type, motor_index, value               | valid && ready
//  cmd     | out | motor_id, speed_magnitude, forward         | valid && ready
//  cfg_*   | in  | cfg_index, cfg_data (kp, ki, kd, min, max)  | cfg_we
//
//  One request enters per cycle while ready is high; a tick or stop reaches its command
//  through an 8-register pipeline (state access, gain multiplies, integrator, period
//  scaling, sum, magnitude, reciprocal divide, output register). Set requests end in the
//  first stage. Reset loads gains and limits with their defaults and clears every motor's
//  state. A stalled output freezes the whole pipeline and drops ready; requests of unused
//  type or for a motor that does not exist are taken and dropped.

module multi_motor_pid_position_loop (
    input  logic                               clk,
    input  logic                               rst_n,
    mmpid_req_if.sink                          req,
    mmpid_cmd_if.source                        cmd,
    input  logic                               cfg_we,
    input  logic [mmpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmpid_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mmpid_pkg::*;

    localparam logic signed [PER_W-1:0]   PERIOD_C = PER_W'(TICK_PERIOD);
    localparam logic signed [MILLI_W-1:0] MILLI_C  = MILLI_W'(MILLI);
    localparam logic [RECIP_W-1:0]        RECIP_C  = RECIP_W'(RECIP);
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // configuration
    logic [GAIN_W-1:0]       kp_reg, ki_reg, kd_reg;
    logic signed [POS_W-1:0] min_pos_reg, max_pos_reg;

    // per-motor state
    logic signed [POS_W-1:0]   target_reg [MOTORS];
    logic signed [ERR_W-1:0]   prev_reg   [MOTORS];
    logic signed [INTEG_W-1:0] integ_reg  [MOTORS];

    logic adv;
    logic req_ok;

    // stage 1: request
    logic                    s1_valid_reg;
    req_kind_t               s1_kind_reg;
    logic [MIDX_W-1:0]       s1_motor_reg;
    logic signed [POS_W-1:0] s1_value_reg;

    logic signed [POS_W-1:0]   tgt_cur;
    logic signed [ERR_W-1:0]   prev_cur;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [POS_W-1:0]   clamp_next;

    // stage 2: error terms
    logic                      s2_valid_reg, s2_stop_reg;
    logic [MIDX_W-1:0]         s2_motor_reg;
    logic signed [ERR_W-1:0]   s2_err_reg;
    logic signed [DELTA_W-1:0] s2_delta_reg;

    logic signed [PROD_W-1:0] kp_err_next, ki_err_next;
    logic signed [KD_W-1:0]   kd_delta_next;

    // stage 3: gain products
    logic                     s3_valid_reg, s3_stop_reg;
    logic [MIDX_W-1:0]        s3_motor_reg;
    logic signed [PROD_W-1:0] s3_kp_err_reg, s3_ki_err_reg;
    logic signed [KD_W-1:0]   s3_kd_delta_reg;

    logic signed [INTEG_W-1:0] integ_cur;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;

    // stage 4: integrator updated
    logic                      s4_valid_reg, s4_stop_reg;
    logic [MIDX_W-1:0]         s4_motor_reg;
    logic signed [PROD_W-1:0]  s4_kp_err_reg;
    logic signed [INTEG_W-1:0] s4_integ_reg;
    logic signed [KD_W-1:0]    s4_kd_delta_reg;

    logic signed [NUM_W-1:0] p_term_next, i_term_next, d_term_next;

    // stage 5: scaled terms
    logic                    s5_valid_reg, s5_stop_reg;
    logic [MIDX_W-1:0]       s5_motor_reg;
    logic signed [NUM_W-1:0] s5_p_term_reg, s5_i_term_reg, s5_d_term_reg;

    logic signed [NUM_W-1:0] num_next;

    // stage 6: numerator
    logic                    s6_valid_reg, s6_stop_reg;
    logic [MIDX_W-1:0]       s6_motor_reg;
    logic signed [NUM_W-1:0] s6_num_reg;

    logic [NUM_W-1:0] num_mag;
    logic             sat_next;

    // stage 7: magnitude
    logic              s7_valid_reg, s7_stop_reg, s7_neg_reg, s7_sat_reg;
    logic [MIDX_W-1:0] s7_motor_reg;
    logic [LO_W-1:0]   s7_lo_reg;

    logic [QPROD_W-1:0] quot_prod;
    logic [MAG_W-1:0]   mag_next;
    logic               fwd_next;

    // output register
    logic              cmd_valid_reg;
    logic [MIDX_W-1:0] cmd_motor_reg;
    logic [MAG_W-1:0]  cmd_mag_reg;
    logic              cmd_fwd_reg;

    assign adv       = !cmd_valid_reg || cmd.ready;
    assign req.ready = adv;

    assign req_ok = (int'(req.payload.motor_index) < MOTORS) &&
                    ((req.payload.req_type == REQ_SET) ||
                     (req.payload.req_type == REQ_TICK) ||
                     (req.payload.req_type == REQ_STOP));

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= GAIN_W'(500);
            ki_reg      <= GAIN_W'(1);
            kd_reg      <= '0;
            min_pos_reg <= {1'b1, {(POS_W-1){1'b0}}};
            max_pos_reg <= {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP:      kp_reg      <= cfg_data[GAIN_W-1:0];
                CFG_KI:      ki_reg      <= cfg_data[GAIN_W-1:0];
                CFG_KD:      kd_reg      <= cfg_data[GAIN_W-1:0];
                CFG_MIN_POS: min_pos_reg <= $signed(cfg_data[POS_W-1:0]);
                CFG_MAX_POS: max_pos_reg <= $signed(cfg_data[POS_W-1:0]);
                default:     ;
            endcase
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= req.valid && req_ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg  <= req_kind_t'(req.payload.req_type);
            s1_motor_reg <= req.payload.motor_index;
            s1_value_reg <= req.payload.value;
        end
    end

    always_comb
    begin
        tgt_cur    = target_reg[s1_motor_reg];
        prev_cur   = prev_reg[s1_motor_reg];
        err_next   = ERR_W'(tgt_cur) - ERR_W'(s1_value_reg);
        delta_next = DELTA_W'(err_next) - DELTA_W'(prev_cur);
        // max_pos wins when the limits cross
        clamp_next = s1_value_reg;
        if (clamp_next < min_pos_reg)
            clamp_next = min_pos_reg;
        if (clamp_next > max_pos_reg)
            clamp_next = max_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                target_reg[m] <= '0;
                prev_reg[m]   <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            unique case (s1_kind_reg)
                REQ_SET:  target_reg[s1_motor_reg] <= clamp_next;
                REQ_STOP: target_reg[s1_motor_reg] <= s1_value_reg;
                REQ_TICK: prev_reg[s1_motor_reg]   <= err_next;
                default:  ;
            endcase
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && (s1_kind_reg != REQ_SET);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_stop_reg  <= (s1_kind_reg == REQ_STOP);
            s2_motor_reg <= s1_motor_reg;
            s2_err_reg   <= err_next;
            s2_delta_reg <= delta_next;
        end
    end

    always_comb
    begin
        kp_err_next   = PROD_W'($signed({1'b0, kp_reg})) * PROD_W'(s2_err_reg);
        ki_err_next   = PROD_W'($signed({1'b0, ki_reg})) * PROD_W'(s2_err_reg);
        kd_delta_next = KD_W'($signed({1'b0, kd_reg})) * KD_W'(s2_delta_reg);
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_stop_reg     <= s2_stop_reg;
            s3_motor_reg    <= s2_motor_reg;
            s3_kp_err_reg   <= kp_err_next;
            s3_ki_err_reg   <= ki_err_next;
            s3_kd_delta_reg <= kd_delta_next;
        end
    end

    always_comb
    begin
        integ_cur = integ_reg[s3_motor_reg];
        integ_sum = (INTEG_W+1)'(integ_cur) + (INTEG_W+1)'(s3_ki_err_reg);
        // saturate when the two top bits disagree
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            integ_next = integ_sum[INTEG_W-1:0];
        if (s3_stop_reg)
            integ_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
                integ_reg[m] <= '0;
        end
        else if (adv && s3_valid_reg)
        begin
            integ_reg[s3_motor_reg] <= integ_next;
        end
    end

    // ---------------- stage 4 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_stop_reg     <= s3_stop_reg;
            s4_motor_reg    <= s3_motor_reg;
            s4_kp_err_reg   <= s3_kp_err_reg;
            s4_integ_reg    <= integ_next;
            s4_kd_delta_reg <= s3_kd_delta_reg;
        end
    end

    always_comb
    begin
        p_term_next = NUM_W'(s4_kp_err_reg) * NUM_W'(PERIOD_C);
        i_term_next = NUM_W'(s4_integ_reg) * NUM_W'(PERIOD_C);
        d_term_next = NUM_W'(s4_kd_delta_reg) * NUM_W'(MILLI_C);
    end

    // ---------------- stage 5 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_stop_reg   <= s4_stop_reg;
            s5_motor_reg  <= s4_motor_reg;
            s5_p_term_reg <= p_term_next;
            s5_i_term_reg <= i_term_next;
            s5_d_term_reg <= d_term_next;
        end
    end

    assign num_next = s5_p_term_reg + s5_i_term_reg + s5_d_term_reg;

    // ---------------- stage 6 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_stop_reg  <= s5_stop_reg;
            s6_motor_reg <= s5_motor_reg;
            s6_num_reg   <= num_next;
        end
    end

    always_comb
    begin
        num_mag  = s6_num_reg[NUM_W-1] ? NUM_W'(-s6_num_reg) : NUM_W'(s6_num_reg);
        sat_next = (num_mag >= NUM_W'(SAT_NUM));
    end

    // ---------------- stage 7 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (adv)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_stop_reg  <= s6_stop_reg;
            s7_motor_reg <= s6_motor_reg;
            s7_neg_reg   <= s6_num_reg[NUM_W-1];
            s7_sat_reg   <= sat_next;
            s7_lo_reg    <= num_mag[LO_W-1:0];
        end
    end

    // Truncating divide of the magnitude by DIVISOR through the reciprocal multiply; sign applied afterward
    always_comb
    begin
        quot_prod = QPROD_W'(s7_lo_reg) * QPROD_W'(RECIP_C);
        mag_next  = s7_sat_reg ? MAG_W'(SPEED_LIMIT) : quot_prod[RECIP_SHIFT +: MAG_W];
        fwd_next  = !s7_neg_reg || (mag_next == '0);
        if (s7_stop_reg)
        begin
            mag_next = '0;
            fwd_next = 1'b0;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (adv)
            cmd_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_motor_reg <= s7_motor_reg;
            cmd_mag_reg   <= mag_next;
            cmd_fwd_reg   <= fwd_next;
        end
    end

    assign cmd.valid                   = cmd_valid_reg;
    assign cmd.payload.motor_id        = cmd_motor_reg;
    assign cmd.payload.speed_magnitude = cmd_mag_reg;
    assign cmd.payload.forward         = cmd_fwd_reg;

    // ---------------- assertions ----------------
    a_mag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> (cmd_mag_reg <= MAG_W'(SPEED_LIMIT)))
        else $error("drive magnitude above the speed limit");

    a_stop_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_valid_reg && s3_stop_reg) |=> (integ_reg[$past(s3_motor_reg)] == '0))
        else $error("stop did not clear the integrator");

    a_sat_gives_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s7_valid_reg && !s7_stop_reg && s7_sat_reg)
        |=> (cmd_mag_reg == MAG_W'(SPEED_LIMIT)))
        else $error("saturated numerator did not give the limit speed");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s7_valid_reg) && $stable(s1_valid_reg) && $stable(s4_valid_reg)))
        else $error("pipeline moved while the output was stalled");

endmodule
